### hw/rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared constants and types for the binary heap priority queue
// ----------------------------------------------------------------------------
package bhpq_pkg;
  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 32;
  localparam int ADDR_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_EXTRACT_TOP = 2'd1,
    CMD_EXTRACT_AT = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  localparam logic [0:0] REG_MIN_FIRST = 1'b0;
  localparam logic [0:0] REG_SIGNED_KEYS = 1'b1;
endpackage

### hw/rtl/bhpq_if.sv
// ----------------------------------------------------------------------------
// bhpq_req_if / bhpq_rsp_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface bhpq_req_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [31:0] key;
  logic [9:0] position;
  modport source (output valid, command, key, position, input ready);
  modport sink (input valid, command, key, position, output ready);
endinterface

interface bhpq_rsp_if;
  logic valid;
  logic ready;
  logic [31:0] value;
  logic [1:0] status;
  logic [10:0] count;
  modport source (output valid, value, status, count, input ready);
  modport sink (input valid, value, status, count, output ready);
endinterface

### hw/rtl/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/binary_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// array heap of keys with insert, extract-top and extract-at-position
// ----------------------------------------------------------------------------
// channel   dir  fields                     notes
// req       in   command, key, position     valid/ready
// rsp       out  value, status, count       valid/ready, one per request
// apb       in   min_first(0x0) signed(0x4) pready always high
//
// one request at a time; ready only while idle
// insert: the new key climbs from the last slot, one parent read and compare per level
// extract-top: the last key replaces the top and descends, reading both children per level
// extract-at: the last key replaces the slot, climbs, and descends if it did not climb
// all through one single-port ram with registered read and one comparator
// reset clears count and config; the key store is not cleared
// a held response keeps the next request waiting in its final state
module binary_heap_priority_queue_unit (
  input  logic                 clk,
  input  logic                 rst,
  bhpq_req_if.sink             req,
  bhpq_rsp_if.source           rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bhpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_RD_OUT, S_RD_LAST, S_GOT_LAST,
    S_DN_RD_L, S_DN_RD_R, S_DN_CMP, S_PUT, S_RESP
  } state_t;

  state_t state;
  logic min_first, signed_keys;
  logic [CNT_BITS-1:0] count;
  logic [ADDR_BITS-1:0] pos;
  logic [KEY_BITS-1:0] cur, lkey, out_val;
  logic have_r, lwin, from_at, moved;
  status_t stat;

  logic ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [KEY_BITS-1:0] ram_wdata, ram_rdata;

  bhpq_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // shared comparator: a ranks strictly above b
  function automatic logic above(input logic [KEY_BITS-1:0] a,
                                 input logic [KEY_BITS-1:0] b,
                                 input logic mf, input logic sg);
    logic [KEY_BITS-1:0] x, y;
    x = a;
    y = b;
    if (sg) begin
      x[KEY_BITS-1] = ~x[KEY_BITS-1];
      y[KEY_BITS-1] = ~y[KEY_BITS-1];
    end
    return mf ? (x < y) : (x > y);
  endfunction

  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic cmp_hit;
  assign cmp_hit = above(cmp_a, cmp_b, min_first, signed_keys);

  logic [ADDR_BITS:0] lch, rch;
  logic [ADDR_BITS-1:0] parent;
  assign lch = {pos, 1'b1};
  assign rch = lch + 1'b1;
  assign parent = (pos - 1'b1) >> 1;

  // climb: sifting key against parent; descend: left child vs key, then
  // right child vs the better of the two
  always_comb begin
    cmp_a = ram_rdata;
    cmp_b = cur;
    if (state == S_UP_CMP) begin
      cmp_a = cur;
      cmp_b = ram_rdata;
    end else if (state == S_DN_CMP && lwin) begin
      cmp_b = lkey;
    end
  end

  // the sifting key stays in cur and is written once at its final slot
  always_comb begin
    ram_we = 1'b0;
    ram_addr = pos;
    ram_wdata = cur;
    unique case (state)
      S_UP_RD: ram_addr = parent;
      S_UP_CMP: begin
        ram_we = cmp_hit;
        ram_wdata = ram_rdata;
      end
      S_RD_LAST: ram_addr = count[ADDR_BITS-1:0];
      S_DN_RD_L: ram_addr = lch[ADDR_BITS-1:0];
      S_DN_RD_R: ram_addr = rch[ADDR_BITS-1:0];
      S_DN_CMP: begin
        ram_we = (have_r && cmp_hit) || lwin;
        ram_wdata = (have_r && cmp_hit) ? ram_rdata : lkey;
      end
      S_PUT: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      min_first <= 1'b0;
      signed_keys <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MIN_FIRST) min_first <= pwdata[0];
        else signed_keys <= pwdata[0];
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            out_val <= '0;
            stat <= ST_OK;
            from_at <= 1'b0;
            moved <= 1'b0;
            unique case (cmd_t'(req.command))
              CMD_INSERT: begin
                if (count >= CNT_BITS'(CAPACITY)) begin
                  stat <= ST_FULL;
                  state <= S_RESP;
                end else begin
                  cur <= req.key;
                  pos <= count[ADDR_BITS-1:0];
                  count <= count + 1'b1;
                  state <= S_UP_RD;
                end
              end
              CMD_EXTRACT_TOP: begin
                if (count == '0) begin
                  stat <= ST_EMPTY;
                  state <= S_RESP;
                end else begin
                  pos <= '0;
                  count <= count - 1'b1;
                  state <= S_RD_OUT;
                end
              end
              CMD_EXTRACT_AT: begin
                if (count == '0) begin
                  stat <= ST_EMPTY;
                  state <= S_RESP;
                end else if (CNT_BITS'(req.position) >= count) begin
                  stat <= ST_BADPOS;
                  state <= S_RESP;
                end else begin
                  pos <= req.position;
                  from_at <= 1'b1;
                  count <= count - 1'b1;
                  state <= S_RD_OUT;
                end
              end
              CMD_NONE: state <= S_RESP;
            endcase
          end
        end
        S_UP_RD: begin
          if (pos == '0) state <= (from_at && !moved) ? S_DN_RD_L : S_PUT;
          else state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (cmp_hit) begin
            // parent key moved down into pos
            pos <= parent;
            moved <= 1'b1;
            state <= S_UP_RD;
          end else begin
            state <= (from_at && !moved) ? S_DN_RD_L : S_PUT;
          end
        end
        S_RD_OUT: state <= S_RD_LAST;
        S_RD_LAST: begin
          out_val <= ram_rdata;
          // removed slot was the last one: nothing moves
          if (CNT_BITS'(pos) == count) state <= S_RESP;
          else state <= S_GOT_LAST;
        end
        S_GOT_LAST: begin
          cur <= ram_rdata;
          state <= from_at ? S_UP_RD : S_DN_RD_L;
        end
        S_DN_RD_L: begin
          if (lch < count) begin
            have_r <= rch < count;
            state <= S_DN_RD_R;
          end else begin
            state <= S_PUT;
          end
        end
        S_DN_RD_R: begin
          lkey <= ram_rdata;
          lwin <= cmp_hit;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (have_r && cmp_hit) begin
            pos <= rch[ADDR_BITS-1:0];
            state <= S_DN_RD_L;
          end else if (lwin) begin
            pos <= lch[ADDR_BITS-1:0];
            state <= S_DN_RD_L;
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: state <= S_RESP;
        S_RESP: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.value <= out_val;
            rsp.status <= stat;
            rsp.count <= count;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (rsp.valid && rsp.ready && state != S_RESP) rsp.valid <= 1'b0;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_FIRST) ? {31'd0, min_first} : {31'd0, signed_keys};
endmodule

### hw/rtl/bhpq_checker.sv
// ----------------------------------------------------------------------------
// bhpq_checker
// port-level checks for the heap unit
// ----------------------------------------------------------------------------
module bhpq_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [1:0] rsp_status,
  input logic [31:0] rsp_value,
  input logic [10:0] rsp_count
);
  import bhpq_pkg::*;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= 11'(CAPACITY)) else $error("count too large");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_value == '0) else $error("value on error");
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("ready during work");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)) else $error("rsp dropped");
endmodule

bind binary_heap_priority_queue_unit bhpq_checker u_bhpq_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
  .rsp_value(rsp.value), .rsp_count(rsp.count)
);

### bench/tb_binary_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue_unit
// self-checking bench for the binary heap priority queue. Each request goes
// through a behavioral heap with the same ranking and tie rules, and every
// response is checked against the queue of expected responses. A directed
// table runs first, then random traffic over several ranking settings.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue_unit;
  import bhpq_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
    logic [10:0] count;
  } rsp_t;

  typedef struct {
    cmd_t        command;
    logic [31:0] key;
    logic [9:0]  position;
    logic        has_rsp;
    rsp_t        rsp;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bhpq_req_if req ();
  bhpq_rsp_if rsp ();

  binary_heap_priority_queue_unit dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // behavioral heap
  logic [31:0] heap_keys [CAPACITY];
  int unsigned heap_len;
  logic cfg_min_first;
  logic cfg_signed;

  rsp_t expected_rsps [$];
  int errors;
  int sent_count;
  int rsp_count;
  int status_hits [4];
  logic hold_rsp;
  logic burst_mode;

  function automatic logic ranks_above(logic [31:0] a, logic [31:0] b);
    logic [31:0] x, y;
    x = a;
    y = b;
    if (cfg_signed) begin
      x[31] = ~x[31];
      y[31] = ~y[31];
    end
    return cfg_min_first ? (x < y) : (x > y);
  endfunction

  function automatic void swap_keys(int unsigned i, int unsigned j);
    logic [31:0] t;
    t = heap_keys[i];
    heap_keys[i] = heap_keys[j];
    heap_keys[j] = t;
  endfunction

  function automatic int unsigned heap_rise(int unsigned pos);
    int unsigned p;
    while (pos > 0) begin
      p = (pos - 1) / 2;
      if (!ranks_above(heap_keys[pos], heap_keys[p])) break;
      swap_keys(pos, p);
      pos = p;
    end
    return pos;
  endfunction

  function automatic void heap_sink(int unsigned pos);
    int unsigned l, r, best;
    forever begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      best = pos;
      if (l < heap_len && ranks_above(heap_keys[l], heap_keys[best])) best = l;
      if (r < heap_len && ranks_above(heap_keys[r], heap_keys[best])) best = r;
      if (best == pos) break;
      swap_keys(best, pos);
      pos = best;
    end
  endfunction

  function automatic rsp_t heap_apply(cmd_t command, logic [31:0] key,
                                      logic [9:0] position);
    rsp_t r;
    int unsigned pos;
    r.value = '0;
    r.status = ST_OK;
    case (command)
      CMD_INSERT: begin
        if (heap_len >= CAPACITY) r.status = ST_FULL;
        else begin
          heap_keys[heap_len] = key;
          heap_len++;
          void'(heap_rise(heap_len - 1));
        end
      end
      CMD_EXTRACT_TOP: begin
        if (heap_len == 0) r.status = ST_EMPTY;
        else begin
          r.value = heap_keys[0];
          heap_len--;
          if (heap_len > 0) begin
            heap_keys[0] = heap_keys[heap_len];
            heap_sink(0);
          end
        end
      end
      CMD_EXTRACT_AT: begin
        if (heap_len == 0) r.status = ST_EMPTY;
        else if (position >= heap_len) r.status = ST_BADPOS;
        else begin
          pos = position;
          r.value = heap_keys[pos];
          heap_len--;
          if (pos != heap_len) begin
            heap_keys[pos] = heap_keys[heap_len];
            if (heap_rise(pos) == pos) heap_sink(pos);
          end
        end
      end
      default: ;
    endcase
    r.count = heap_len[10:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  // apb write in setup and access cycles, driven on falling edges
  task automatic reg_write(logic [0:0] index, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_MIN_FIRST) cfg_min_first = data[0];
    else cfg_signed = data[0];
  endtask

  task automatic wait_drained();
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_request(cmd_t command, logic [31:0] key, logic [9:0] position,
                              logic has_rsp, rsp_t typed_rsp);
    rsp_t r;
    @(negedge clk);
    req.valid <= 1'b1;
    req.command <= command;
    req.key <= key;
    req.position <= position;
    do @(posedge clk); while (!req.ready);
    r = heap_apply(command, key, position);
    if (has_rsp && r != typed_rsp) begin
      $error("table rsp exp %h got %h", typed_rsp, r);
      errors++;
    end
    expected_rsps.push_back(r);
    sent_count++;
    // drop valid once taken; gaps only outside a burst
    @(negedge clk);
    req.valid <= 1'b0;
    if (!burst_mode) repeat ($urandom_range(0, 4)) @(negedge clk);
  endtask

  function automatic rsp_t mk(logic [31:0] v, status_t s, logic [10:0] c);
    rsp_t r;
    r.value = v;
    r.status = s;
    r.count = c;
    return r;
  endfunction

  // response side: random stall pattern plus a long hold when asked
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.value = rsp.value;
      got.status = status_t'(rsp.status);
      got.count = rsp.count;
      if (expected_rsps.size() == 0) begin
        $error("response with none expected: %h", got);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        rsp_count++;
        status_hits[want.status]++;
        if (got.value !== want.value) begin
          $error("value exp %h got %h", want.value, got.value);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          errors++;
        end
        if (got.count !== want.count) begin
          $error("count exp %0d got %0d", want.count, got.count);
          errors++;
        end
      end
    end
  end

  task automatic random_phase(int n, int key_span);
    cmd_t c;
    logic [31:0] k;
    logic [9:0] p;
    int pick;
    for (int i = 0; i < n; i++) begin
      burst_mode = ($urandom_range(0, 5) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) c = CMD_INSERT;
      else if (pick < 70) c = CMD_EXTRACT_TOP;
      else if (pick < 97) c = CMD_EXTRACT_AT;
      else c = CMD_NONE;
      if (key_span == 0) k = $urandom();
      else k = 32'($urandom_range(0, key_span) - key_span / 2);
      if ($urandom_range(0, 4) == 0) p = 10'($urandom());
      else p = 10'($urandom_range(0, heap_len + 1));
      send_request(c, k, p, 1'b0, '0);
      if ($urandom_range(0, 30) == 0) repeat ($urandom_range(5, 40)) @(negedge clk);
    end
    burst_mode = 1'b0;
  endtask

  stim_row_t rows [$];

  initial begin
    rsp_t none;
    none = '0;
    errors = 0;
    sent_count = 0;
    rsp_count = 0;
    heap_len = 0;
    cfg_min_first = 1'b0;
    cfg_signed = 1'b0;
    hold_rsp = 1'b0;
    burst_mode = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.command = CMD_NONE;
    req.key = '0;
    req.position = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows = '{
      '{CMD_EXTRACT_TOP, 32'h0, 10'd0, 1'b1, mk(32'h0, ST_EMPTY, 11'd0)},
      '{CMD_EXTRACT_AT, 32'h0, 10'd1023, 1'b1, mk(32'h0, ST_EMPTY, 11'd0)},
      '{CMD_NONE, 32'hffffffff, 10'd0, 1'b1, mk(32'h0, ST_OK, 11'd0)},
      '{CMD_INSERT, 32'h0, 10'd0, 1'b1, mk(32'h0, ST_OK, 11'd1)},
      '{CMD_INSERT, 32'hffffffff, 10'h3ff, 1'b1, mk(32'h0, ST_OK, 11'd2)},
      '{CMD_INSERT, 32'h80000000, 10'd0, 1'b1, mk(32'h0, ST_OK, 11'd3)},
      '{CMD_INSERT, 32'h7fffffff, 10'd0, 1'b0, none},
      '{CMD_INSERT, 32'h7fffffff, 10'd0, 1'b0, none},
      '{CMD_EXTRACT_AT, 32'h0, 10'd5, 1'b1, mk(32'h0, ST_BADPOS, 11'd5)},
      '{CMD_EXTRACT_AT, 32'h0, 10'd1023, 1'b1, mk(32'h0, ST_BADPOS, 11'd5)},
      '{CMD_EXTRACT_TOP, 32'h0, 10'd0, 1'b1, mk(32'hffffffff, ST_OK, 11'd4)},
      '{CMD_EXTRACT_AT, 32'h0, 10'd3, 1'b0, none},
      '{CMD_EXTRACT_AT, 32'h0, 10'd1, 1'b0, none},
      '{CMD_NONE, 32'h0, 10'd0, 1'b1, mk(32'h0, ST_OK, 11'd2)},
      '{CMD_EXTRACT_TOP, 32'h0, 10'd0, 1'b0, none},
      '{CMD_EXTRACT_TOP, 32'h0, 10'd0, 1'b0, none},
      '{CMD_EXTRACT_TOP, 32'h0, 10'd0, 1'b1, mk(32'h0, ST_EMPTY, 11'd0)}
    };
    foreach (rows[i])
      send_request(rows[i].command, rows[i].key, rows[i].position,
                   rows[i].has_rsp, rows[i].rsp);
    wait_drained();

    // four ranking settings, extremes included
    for (int s = 0; s < 4; s++) begin
      reg_write(REG_MIN_FIRST, {31'h0, s[0]});
      reg_write(REG_SIGNED_KEYS, {31'h0, s[1]});
      random_phase(120, (s == 3) ? 16 : 0);
      if (s == 1) begin
        // hold responses long enough to back up requests
        fork
          begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clk);
            hold_rsp = 1'b0;
          end
          random_phase(10, 0);
        join
      end
      wait_drained();
    end

    random_phase(45, 0);
    wait_drained();

    $display("sent %0d requests, checked %0d responses", sent_count, rsp_count);
    $display("ok %0d empty %0d full %0d badpos %0d", status_hits[0], status_hits[1],
             status_hits[2], status_hits[3]);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

### files.f
hw/rtl/bhpq_pkg.sv
hw/rtl/bhpq_if.sv
hw/rtl/bhpq_ram.sv
hw/rtl/binary_heap_priority_queue_unit.sv
hw/rtl/bhpq_checker.sv
bench/tb_binary_heap_priority_queue_unit.sv
